// File: src/sgi_pkg.sv
`default_nettype none
package sgi_pkg;

   // Coordinate format and internal widths.
   localparam int COORD_BITS = 16;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int SQ_W       = COORD_BITS + 2;
   localparam int EQ_W       = COORD_BITS + 3;
   localparam int PROD_W     = 2 * COORD_BITS + 6;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MNUM_W     = 2 * COORD_BITS + 3;
   localparam int NUM_W      = MNUM_W + COORD_BITS;
   localparam int MAG_W      = NUM_W - 1;
   localparam int DENM_W     = 2 * COORD_BITS;
   localparam int QUOT_W     = COORD_BITS + 1;
   localparam int FIN_W      = COORD_BITS + 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_dir_x;
      coord_type a_dir_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_dir_x;
      coord_type b_dir_y;
   } req_type;

   typedef struct packed {
      logic      hit;
      coord_type point_x;
      coord_type point_y;
   } rsp_type;

   // Per-item data that travels beside the divider.
   typedef struct packed {
      logic      nonpar;
      logic      hit;
      coord_type point_x;
      coord_type point_y;
      coord_type a_start_x;
      coord_type a_start_y;
   } side_type;

   // One divider lane result: sign, overflow and quotient magnitude.
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } lane_type;

   // Clamps a wide signed value into the coordinate range.
   function automatic coord_type sat_coord(input logic signed [FIN_W-1:0] v);
      logic same;
      same = (v[FIN_W-1:COORD_BITS-1] == {(FIN_W-COORD_BITS+1){1'b0}}) ||
             (v[FIN_W-1:COORD_BITS-1] == {(FIN_W-COORD_BITS+1){1'b1}});
      if (same) begin
         return v[COORD_BITS-1:0];
      end
      return v[FIN_W-1] ? COORD_MIN : COORD_MAX;
   endfunction

endpackage
`default_nettype wire

// File: src/sgi_front.sv
`default_nettype none
module sgi_front (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  wire                                   in_valid,
   input  sgi_pkg::req_type                      in_data,
   output logic                                  out_valid,
   output logic signed [sgi_pkg::NUM_W-1:0]      out_num_x,
   output logic signed [sgi_pkg::NUM_W-1:0]      out_num_y,
   output logic [sgi_pkg::DENM_W-1:0]            out_den,
   output sgi_pkg::side_type                     out_side
);
   import sgi_pkg::*;

   // Stage 1: input register and coordinate differences.
   logic                      v1_ff;
   req_type                   r1_ff;
   logic signed [DIFF_W-1:0]  dx1_ff, dy1_ff;
   logic signed [SQ_W-1:0]    sqx1_ff, sqy1_ff, ex1_ff, ey1_ff;
   logic signed [EQ_W-1:0]    eqx1_ff, eqy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         r1_ff   <= in_data;
         dx1_ff  <= DIFF_W'(in_data.b_start_x) - DIFF_W'(in_data.a_start_x);
         dy1_ff  <= DIFF_W'(in_data.b_start_y) - DIFF_W'(in_data.a_start_y);
         sqx1_ff <= SQ_W'(in_data.b_start_x) + SQ_W'(in_data.b_dir_x)
                    - SQ_W'(in_data.a_start_x);
         sqy1_ff <= SQ_W'(in_data.b_start_y) + SQ_W'(in_data.b_dir_y)
                    - SQ_W'(in_data.a_start_y);
         ex1_ff  <= SQ_W'(in_data.b_start_x) - SQ_W'(in_data.a_start_x)
                    - SQ_W'(in_data.a_dir_x);
         ey1_ff  <= SQ_W'(in_data.b_start_y) - SQ_W'(in_data.a_start_y)
                    - SQ_W'(in_data.a_dir_y);
         eqx1_ff <= EQ_W'(in_data.b_start_x) + EQ_W'(in_data.b_dir_x)
                    - EQ_W'(in_data.a_start_x) - EQ_W'(in_data.a_dir_x);
         eqy1_ff <= EQ_W'(in_data.b_start_y) + EQ_W'(in_data.b_dir_y)
                    - EQ_W'(in_data.a_start_y) - EQ_W'(in_data.a_dir_y);
      end
   end

   // Stage 2: all cross and dot product terms, A's clamped end point and degenerate flags.
   logic                      v2_ff;
   coord_type                 ax2_ff, ay2_ff, adx2_ff, ady2_ff;
   coord_type                 aex2_ff, aey2_ff;
   logic                      adeg2_ff, bdeg2_ff, dz2_ff;
   logic signed [PROD_W-1:0]  pden1_ff, pden2_ff, pm1_ff, pm2_ff, pn1_ff, pn2_ff;
   logic signed [PROD_W-1:0]  pt1_ff, pt2_ff, pl1_ff, pl2_ff;
   logic signed [PROD_W-1:0]  pss1_ff, pss2_ff, psq1_ff, psq2_ff;
   logic signed [PROD_W-1:0]  pes1_ff, pes2_ff, peq1_ff, peq2_ff, pd1_ff, pd2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         ax2_ff   <= r1_ff.a_start_x;
         ay2_ff   <= r1_ff.a_start_y;
         adx2_ff  <= r1_ff.a_dir_x;
         ady2_ff  <= r1_ff.a_dir_y;
         aex2_ff  <= sat_coord(FIN_W'(r1_ff.a_start_x) + FIN_W'(r1_ff.a_dir_x));
         aey2_ff  <= sat_coord(FIN_W'(r1_ff.a_start_y) + FIN_W'(r1_ff.a_dir_y));
         adeg2_ff <= (r1_ff.a_dir_x == '0) && (r1_ff.a_dir_y == '0);
         bdeg2_ff <= (r1_ff.b_dir_x == '0) && (r1_ff.b_dir_y == '0);
         dz2_ff   <= (dx1_ff == '0) && (dy1_ff == '0);
         pden1_ff <= PROD_W'(r1_ff.a_dir_x) * PROD_W'(r1_ff.b_dir_y);
         pden2_ff <= PROD_W'(r1_ff.b_dir_x) * PROD_W'(r1_ff.a_dir_y);
         pm1_ff   <= PROD_W'(r1_ff.b_dir_y) * PROD_W'(dx1_ff);
         pm2_ff   <= PROD_W'(r1_ff.b_dir_x) * PROD_W'(dy1_ff);
         pn1_ff   <= PROD_W'(r1_ff.a_dir_y) * PROD_W'(dx1_ff);
         pn2_ff   <= PROD_W'(r1_ff.a_dir_x) * PROD_W'(dy1_ff);
         pt1_ff   <= PROD_W'(dx1_ff) * PROD_W'(r1_ff.b_dir_x);
         pt2_ff   <= PROD_W'(dy1_ff) * PROD_W'(r1_ff.b_dir_y);
         pl1_ff   <= PROD_W'(r1_ff.b_dir_x) * PROD_W'(r1_ff.b_dir_x);
         pl2_ff   <= PROD_W'(r1_ff.b_dir_y) * PROD_W'(r1_ff.b_dir_y);
         pss1_ff  <= PROD_W'(dx1_ff) * PROD_W'(r1_ff.a_dir_x);
         pss2_ff  <= PROD_W'(dy1_ff) * PROD_W'(r1_ff.a_dir_y);
         psq1_ff  <= PROD_W'(sqx1_ff) * PROD_W'(r1_ff.a_dir_x);
         psq2_ff  <= PROD_W'(sqy1_ff) * PROD_W'(r1_ff.a_dir_y);
         pes1_ff  <= PROD_W'(ex1_ff) * PROD_W'(r1_ff.a_dir_x);
         pes2_ff  <= PROD_W'(ey1_ff) * PROD_W'(r1_ff.a_dir_y);
         peq1_ff  <= PROD_W'(eqx1_ff) * PROD_W'(r1_ff.a_dir_x);
         peq2_ff  <= PROD_W'(eqy1_ff) * PROD_W'(r1_ff.a_dir_y);
         pd1_ff   <= PROD_W'(dx1_ff) * PROD_W'(sqx1_ff);
         pd2_ff   <= PROD_W'(dy1_ff) * PROD_W'(sqy1_ff);
      end
   end

   // Stage 3: sums of the product terms.
   logic                      v3_ff;
   coord_type                 ax3_ff, ay3_ff, adx3_ff, ady3_ff, aex3_ff, aey3_ff;
   logic                      adeg3_ff, bdeg3_ff, dz3_ff;
   logic signed [SUM_W-1:0]   den3_ff, mnum3_ff, nnum3_ff, t3_ff, tl3_ff;
   logic signed [SUM_W-1:0]   dss3_ff, dsq3_ff, des3_ff, deq3_ff, dd3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         ax3_ff   <= ax2_ff;
         ay3_ff   <= ay2_ff;
         adx3_ff  <= adx2_ff;
         ady3_ff  <= ady2_ff;
         aex3_ff  <= aex2_ff;
         aey3_ff  <= aey2_ff;
         adeg3_ff <= adeg2_ff;
         bdeg3_ff <= bdeg2_ff;
         dz3_ff   <= dz2_ff;
         den3_ff  <= SUM_W'(pden1_ff) - SUM_W'(pden2_ff);
         mnum3_ff <= SUM_W'(pm1_ff) - SUM_W'(pm2_ff);
         nnum3_ff <= SUM_W'(pn1_ff) - SUM_W'(pn2_ff);
         t3_ff    <= SUM_W'(pt1_ff) + SUM_W'(pt2_ff);
         tl3_ff   <= SUM_W'(pt1_ff) + SUM_W'(pt2_ff) + SUM_W'(pl1_ff) + SUM_W'(pl2_ff);
         dss3_ff  <= SUM_W'(pss1_ff) + SUM_W'(pss2_ff);
         dsq3_ff  <= SUM_W'(psq1_ff) + SUM_W'(psq2_ff);
         des3_ff  <= SUM_W'(pes1_ff) + SUM_W'(pes2_ff);
         deq3_ff  <= SUM_W'(peq1_ff) + SUM_W'(peq2_ff);
         dd3_ff   <= SUM_W'(pd1_ff) + SUM_W'(pd2_ff);
      end
   end

   // Stage 4: case decisions and sign normalisation of the parameters.
   logic                      v4_ff;
   coord_type                 ax4_ff, ay4_ff, adx4_ff, ady4_ff;
   logic                      nonpar4_ff, bhit4_ff;
   coord_type                 bpx4_ff, bpy4_ff;
   logic signed [SUM_W-1:0]   den4_ff, mnum4_ff, nnum4_ff;
   logic                      bhit_in;
   coord_type                 bpx_in, bpy_in;

   always_comb begin
      bhit_in = 1'b0;
      bpx_in  = '0;
      bpy_in  = '0;
      if (adeg3_ff) begin
         // A is a single point: it must lie on B.
         if (bdeg3_ff ? dz3_ff
                      : ((mnum3_ff == '0) && (t3_ff <= 0) && (tl3_ff >= 0))) begin
            bhit_in = 1'b1;
            bpx_in  = ax3_ff;
            bpy_in  = ay3_ff;
         end
      end else if (nnum3_ff == '0) begin
         // Collinear: overlap test on the dot products.
         if (!((dss3_ff < 0 && dsq3_ff < 0) || (des3_ff > 0 && deq3_ff > 0))) begin
            bhit_in = 1'b1;
            if (dd3_ff < 0) begin
               bpx_in = ax3_ff;
               bpy_in = ay3_ff;
            end else begin
               bpx_in = aex3_ff;
               bpy_in = aey3_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         ax4_ff     <= ax3_ff;
         ay4_ff     <= ay3_ff;
         adx4_ff    <= adx3_ff;
         ady4_ff    <= ady3_ff;
         nonpar4_ff <= den3_ff != '0;
         bhit4_ff   <= bhit_in;
         bpx4_ff    <= bpx_in;
         bpy4_ff    <= bpy_in;
         den4_ff    <= den3_ff[SUM_W-1] ? -den3_ff : den3_ff;
         mnum4_ff   <= den3_ff[SUM_W-1] ? -mnum3_ff : mnum3_ff;
         nnum4_ff   <= den3_ff[SUM_W-1] ? -nnum3_ff : nnum3_ff;
      end
   end

   // Stage 5: hit test in range and dividend products.
   logic                      v5_ff;
   logic signed [MNUM_W-1:0]  mnum_s;
   logic                      hitnp;

   assign mnum_s = mnum4_ff[MNUM_W-1:0];
   assign hitnp  = !mnum4_ff[SUM_W-1] && (mnum4_ff <= den4_ff) &&
                   !nnum4_ff[SUM_W-1] && (nnum4_ff <= den4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         out_num_x          <= NUM_W'(adx4_ff) * NUM_W'(mnum_s);
         out_num_y          <= NUM_W'(ady4_ff) * NUM_W'(mnum_s);
         out_den            <= den4_ff[DENM_W-1:0];
         out_side.nonpar    <= nonpar4_ff;
         out_side.hit       <= nonpar4_ff ? hitnp : bhit4_ff;
         out_side.point_x   <= bpx4_ff;
         out_side.point_y   <= bpy4_ff;
         out_side.a_start_x <= ax4_ff;
         out_side.a_start_y <= ay4_ff;
      end
   end

   assign out_valid = v5_ff;

endmodule
`default_nettype wire

// File: src/sgi_div.sv
`default_nettype none
module sgi_div (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  wire                                   in_valid,
   input  wire  signed [sgi_pkg::NUM_W-1:0]      in_num_x,
   input  wire  signed [sgi_pkg::NUM_W-1:0]      in_num_y,
   input  wire  [sgi_pkg::DENM_W-1:0]            in_den,
   input  sgi_pkg::side_type                     in_side,
   output logic                                  out_valid,
   output sgi_pkg::lane_type                     out_x,
   output sgi_pkg::lane_type                     out_y,
   output sgi_pkg::side_type                     out_side
);
   import sgi_pkg::*;

   // Sign and magnitude of both dividends.
   logic              va_ff;
   logic              nxa_ff, nya_ff;
   logic [MAG_W-1:0]  mxa_ff, mya_ff;
   logic [DENM_W-1:0] dena_ff;
   side_type          sa_ff;
   logic signed [NUM_W-1:0] absx, absy;

   assign absx = in_num_x[NUM_W-1] ? -in_num_x : in_num_x;
   assign absy = in_num_y[NUM_W-1] ? -in_num_y : in_num_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
      if (en) begin
         nxa_ff  <= in_num_x[NUM_W-1];
         nya_ff  <= in_num_y[NUM_W-1];
         mxa_ff  <= absx[MAG_W-1:0];
         mya_ff  <= absy[MAG_W-1:0];
         dena_ff <= in_den;
         sa_ff   <= in_side;
      end
   end

   // Per-stage registers; index zero holds the overflow check result.
   logic [QUOT_W:0]              v_ff;
   logic [QUOT_W:0]              nx_ff, ny_ff, ox_ff, oy_ff;
   logic [QUOT_W:0][MAG_W-1:0]   rx_ff, ry_ff;
   logic [QUOT_W:0][QUOT_W-1:0]  qx_ff, qy_ff;
   logic [QUOT_W:0][DENM_W-1:0]  d_ff;
   side_type                     s_ff [QUOT_W+1];
   logic [MAG_W-1:0]             lim;

   // A quotient beyond the quotient width saturates any result.
   assign lim = MAG_W'({dena_ff, {QUOT_W{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= va_ff;
      end
      if (en) begin
         nx_ff[0] <= nxa_ff;
         ny_ff[0] <= nya_ff;
         ox_ff[0] <= mxa_ff >= lim;
         oy_ff[0] <= mya_ff >= lim;
         rx_ff[0] <= mxa_ff;
         ry_ff[0] <= mya_ff;
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         d_ff[0]  <= dena_ff;
         s_ff[0]  <= sa_ff;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
      localparam int Sh = QUOT_W - k;
      logic [MAG_W-1:0] dsh;
      logic             gx, gy;

      assign dsh = MAG_W'(d_ff[k-1]) << Sh;
      assign gx  = rx_ff[k-1] >= dsh;
      assign gy  = ry_ff[k-1] >= dsh;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (en) begin
            nx_ff[k] <= nx_ff[k-1];
            ny_ff[k] <= ny_ff[k-1];
            ox_ff[k] <= ox_ff[k-1];
            oy_ff[k] <= oy_ff[k-1];
            rx_ff[k] <= gx ? rx_ff[k-1] - dsh : rx_ff[k-1];
            ry_ff[k] <= gy ? ry_ff[k-1] - dsh : ry_ff[k-1];
            qx_ff[k] <= qx_ff[k-1] | (QUOT_W'(gx) << Sh);
            qy_ff[k] <= qy_ff[k-1] | (QUOT_W'(gy) << Sh);
            d_ff[k]  <= d_ff[k-1];
            s_ff[k]  <= s_ff[k-1];
         end
      end
   end

   assign out_valid  = v_ff[QUOT_W];
   assign out_x.neg  = nx_ff[QUOT_W];
   assign out_x.ovf  = ox_ff[QUOT_W];
   assign out_x.quot = qx_ff[QUOT_W];
   assign out_y.neg  = ny_ff[QUOT_W];
   assign out_y.ovf  = oy_ff[QUOT_W];
   assign out_y.quot = qy_ff[QUOT_W];
   assign out_side   = s_ff[QUOT_W];

endmodule
`default_nettype wire

// File: src/segment_intersection.sv
// Segment intersection test. Each item carries two segments as a start
// point and a direction vector in signed Q11.4; the result item gives a hit
// flag and a point, saturated to 16 bits. The block is a fixed pipeline of
// 25 register stages: five for the cross and dot products and the case
// decisions, two for dividend sign and range check, seventeen for the
// restoring divider (one quotient bit each) and one output register. It
// takes one item every cycle unless the pipeline is held. A stall on the
// result side while a result is offered holds the whole pipeline and is
// passed back to the input the same cycle.
`default_nettype none
module segment_intersection (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  sgi_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output sgi_pkg::rsp_type   rsp_data
);
   import sgi_pkg::*;

   logic                    en;
   logic                    fv, dv;
   logic signed [NUM_W-1:0] num_x, num_y;
   logic [DENM_W-1:0]       den;
   side_type                fside, dside;
   lane_type                lx, ly;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   // The pipeline moves whenever the output register is free or taken.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fv),
      .out_num_x (num_x),
      .out_num_y (num_y),
      .out_den   (den),
      .out_side  (fside)
   );

   sgi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fv),
      .in_num_x  (num_x),
      .in_num_y  (num_y),
      .in_den    (den),
      .in_side   (fside),
      .out_valid (dv),
      .out_x     (lx),
      .out_y     (ly),
      .out_side  (dside)
   );

   // Signed quotient added to A's start, then clamped.
   function automatic coord_type lane_point(input lane_type l, input coord_type base);
      logic signed [FIN_W-1:0] q;
      q = l.neg ? -FIN_W'(l.quot) : FIN_W'(l.quot);
      if (l.ovf) begin
         return l.neg ? COORD_MIN : COORD_MAX;
      end
      return sat_coord(FIN_W'(base) + q);
   endfunction

   always_comb begin
      rsp_in.hit = dside.hit;
      if (dside.nonpar) begin
         rsp_in.point_x = lane_point(lx, dside.a_start_x);
         rsp_in.point_y = lane_point(ly, dside.a_start_y);
      end else begin
         rsp_in.point_x = dside.point_x;
         rsp_in.point_y = dside.point_y;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: verif/tb.sv
`default_nettype none
module tb;
   import sgi_pkg::*;

   // Expected result of one segment pair, worked out in exact integer arithmetic.
   function automatic rsp_type crossing_of(input req_type r);
      rsp_type o;
      longint ax, ay, adx, ady, bdx, bdy, dx, dy, den, mnum, nnum, px, py;
      longint sqx, sqy, d_ss, d_sq, d_es, d_eq, t, len2;
      bit on;
      ax = r.a_start_x; ay = r.a_start_y; adx = r.a_dir_x; ady = r.a_dir_y;
      bdx = r.b_dir_x; bdy = r.b_dir_y;
      dx = longint'(r.b_start_x) - ax; dy = longint'(r.b_start_y) - ay;
      den = adx * bdy - bdx * ady;
      o.hit = 1'b0; px = 0; py = 0;
      if (den != 0) begin
         mnum = bdy * dx - bdx * dy;
         nnum = ady * dx - adx * dy;
         if (den < 0) begin
            den = -den; mnum = -mnum; nnum = -nnum;
         end
         o.hit = mnum >= 0 && mnum <= den && nnum >= 0 && nnum <= den;
         px = ax + (adx * mnum) / den;
         py = ay + (ady * mnum) / den;
      end else if (adx == 0 && ady == 0) begin
         // Degenerate A: a single point tested against B.
         if (bdx == 0 && bdy == 0) begin
            on = dx == 0 && dy == 0;
         end else begin
            t = dx * bdx + dy * bdy;
            len2 = bdx * bdx + bdy * bdy;
            on = (bdx * dy == dx * bdy) && t <= 0 && t >= -len2;
         end
         if (on) begin
            o.hit = 1'b1; px = ax; py = ay;
         end
      end else if (adx * dy == dx * ady) begin
         // Collinear: overlap by dot products.
         sqx = dx + bdx; sqy = dy + bdy;
         d_ss = dx * adx + dy * ady;
         d_sq = sqx * adx + sqy * ady;
         d_es = (dx - adx) * adx + (dy - ady) * ady;
         d_eq = (sqx - adx) * adx + (sqy - ady) * ady;
         if (!((d_ss < 0 && d_sq < 0) || (d_es > 0 && d_eq > 0))) begin
            o.hit = 1'b1;
            if (dx * sqx + dy * sqy < 0) begin
               px = ax; py = ay;
            end else begin
               px = ax + adx; py = ay + ady;
            end
         end
      end
      if (px > 32767) px = 32767;
      if (px < -32768) px = -32768;
      if (py > 32767) py = 32767;
      if (py < -32768) py = -32768;
      o.point_x = coord_type'(px);
      o.point_y = coord_type'(py);
      return o;
   endfunction

   // Holds the results still owed by the block, oldest first.
   class crossing_board;
      rsp_type owed[$];
      int      errors;
      function void note_pair(input req_type r);
         owed.push_back(crossing_of(r));
      endfunction
      function void check_result(input rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            $display("%0t: result with none owed: %p", $time, got);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (got.hit !== e.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, got.hit);
            errors++;
         end
         if (got.point_x !== e.point_x) begin
            $display("%0t: point_x expected %0d actual %0d", $time, e.point_x, got.point_x);
            errors++;
         end
         if (got.point_y !== e.point_y) begin
            $display("%0t: point_y expected %0d actual %0d", $time, e.point_y, got.point_y);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   crossing_board board = new();
   bit quiet_send = 1'b0;
   bit quiet_recv = 1'b0;
   int hold_cycles = 0;
   int rsp_seen = 0;
   bit hold_done = 1'b0;

   always #6 clock = ~clock;

   segment_intersection i_dut (.*);

   // Result side: random stalls, one long hold-off, checking at each accepted item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_data);
         rsp_seen <= rsp_seen + 1;
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_seen >= 500) begin
         hold_done <= 1'b1;
         hold_cycles <= 80;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_recv && ($urandom_range(99) < 11);
      end
   end

   // Offers one pair, with random gaps, and waits until it is taken.
   task automatic send_pair(input req_type r);
      while (!quiet_send && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_pair(r);
   endtask

   function automatic coord_type edge_val();
      case ($urandom_range(5))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 16'sd0;
         3: return 16'sd1;
         4: return -16'sd1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type small_val();
      return coord_type'($signed($urandom_range(64)) - 32);
   endfunction

   // Random pair shaped so that parallel, collinear and degenerate cases come up often.
   function automatic req_type random_pair();
      req_type r;
      int k, m;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      case ($urandom_range(9))
         0, 1: ;
         2: begin
            r.a_start_x = small_val(); r.a_start_y = small_val();
            r.a_dir_x = small_val(); r.a_dir_y = small_val();
            r.b_start_x = small_val(); r.b_start_y = small_val();
            r.b_dir_x = small_val(); r.b_dir_y = small_val();
         end
         3, 4: begin
            // Collinear along one line.
            r.a_dir_x = small_val(); r.a_dir_y = small_val();
            r.a_start_x = small_val(); r.a_start_y = small_val();
            k = $signed($urandom_range(6)) - 3; m = $signed($urandom_range(6)) - 3;
            r.b_start_x = coord_type'(r.a_start_x + k * r.a_dir_x);
            r.b_start_y = coord_type'(r.a_start_y + k * r.a_dir_y);
            r.b_dir_x = coord_type'(m * r.a_dir_x);
            r.b_dir_y = coord_type'(m * r.a_dir_y);
         end
         5: begin
            // Parallel, offset.
            m = $signed($urandom_range(6)) - 3;
            r.a_dir_x = small_val(); r.a_dir_y = small_val();
            r.b_dir_x = coord_type'(m * r.a_dir_x);
            r.b_dir_y = coord_type'(m * r.a_dir_y);
            r.b_start_x = r.a_start_x + small_val();
         end
         6: begin
            // Degenerate A on or near B.
            r.a_dir_x = 0; r.a_dir_y = 0;
            r.b_start_x = small_val(); r.b_start_y = small_val();
            r.b_dir_x = small_val(); r.b_dir_y = small_val();
            k = $urandom_range(4);
            r.a_start_x = coord_type'(r.b_start_x + (k * r.b_dir_x) / 2
                                      + $signed($urandom_range(1)));
            r.a_start_y = coord_type'(r.b_start_y + (k * r.b_dir_y) / 2);
            if ($urandom_range(3) == 0) begin
               r.b_dir_x = 0; r.b_dir_y = 0;
               r.b_start_x = coord_type'(r.a_start_x + $signed($urandom_range(1)));
               r.b_start_y = r.a_start_y;
            end
         end
         default: begin
            r.a_start_x = edge_val(); r.a_start_y = edge_val();
            r.a_dir_x = edge_val(); r.a_dir_y = edge_val();
            r.b_start_x = edge_val(); r.b_start_y = edge_val();
            r.b_dir_x = edge_val(); r.b_dir_y = edge_val();
         end
      endcase
      return r;
   endfunction

   // Directed cases, then random pairs under varying pressure.
   initial begin
      req_type r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Crossing, miss, parallel, collinear both ways, degenerate, extremes.
      send_pair('{0, 0, 160, 160, 0, 160, 160, -160});
      send_pair('{0, 0, 16, 16, 100, 0, 16, -16});
      send_pair('{0, 0, 32, 0, 0, 16, 32, 0});
      send_pair('{0, 0, 32, 0, 16, 0, 32, 0});
      send_pair('{16, 0, 32, 0, 0, 0, 48, 0});
      send_pair('{0, 0, 16, 0, 64, 0, 16, 0});
      send_pair('{0, 0, 32, 0, 32, 0, -16, 0});
      send_pair('{8, 8, 0, 0, 0, 0, 16, 16});
      send_pair('{8, 9, 0, 0, 0, 0, 16, 16});
      send_pair('{5, 5, 0, 0, 5, 5, 0, 0});
      send_pair('{5, 5, 0, 0, 5, 6, 0, 0});
      send_pair('{0, 0, 0, 0, 16, 0, -16, 0});
      send_pair('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, COORD_MIN, COORD_MAX});
      send_pair('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX});
      send_pair('{COORD_MIN, 0, COORD_MAX, 1, 0, COORD_MIN, 1, COORD_MAX});
      send_pair('{COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0});
      send_pair('{-1, -1, -1, -1, -1, 0, 1, -1});
      send_pair('1);
      send_pair('0);
      for (int i = 0; i < 950; i++) begin
         quiet_send = i >= 300 && i < 400;
         quiet_recv = i >= 300 && i < 400;
         if (i == 700) begin
            // Let every owed result drain before carrying on.
            req_valid <= 1'b0;
            @(posedge clock);
            while (board.owed.size() != 0) @(posedge clock);
         end
         send_pair(random_pair());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
